>>> src/fsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables for the Fourier shift phase ramp.
package fsp_pkg;

  localparam int MAX_DIM       = 1024;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int STAGES_EFF    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int ITER_W        = (STAGES_EFF > 1) ? $clog2(STAGES_EFF) : 1;
  localparam int TAB_W         = $clog2(TABLE_LEN);

  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 32;
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int SIZE_W     = (IDX_W + 1 > CFG_SIZE_W) ? IDX_W + 1 : CFG_SIZE_W;

  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] CORDIC_GAIN_Q30 = GAIN_W'(652032874);
  localparam int VEC_W  = 34;
  localparam int ANG_W  = PHASE_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_STEP_X = 3'd3,
    REG_STEP_Y = 3'd4,
    REG_STEP_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_re;
    logic signed [SAMPLE_W-1:0] out_im;
    logic                       frame_last;
  } out_item_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       neg;
    logic signed [PHASE_W-1:0]  ang;
    logic                       last;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [GAIN_W-1:0] atan_turn(input logic [TAB_W-1:0] idx);
    logic [GAIN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/fsp_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, raster counters and phase accumulation.
module fsp_front import fsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  push,
  output job_t                  push_job,
  input  q_stat_t               q_stat
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  localparam int F_W = SIZE_W + 1;

  fstate_t state_r, state_nxt;
  axis_t   axis_r, axis_nxt;

  logic [CFG_SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [PHASE_W-1:0]    step_x_r, step_y_r, step_z_r;
  logic [IDX_W-1:0]      x_index_r, y_index_r, z_index_r;
  logic [IDX_W-1:0]      x_index_nxt, y_index_nxt, z_index_nxt;
  logic [PHASE_W-1:0]    phi_r, phi_nxt;
  in_item_t              smp_r;
  logic                  last_r;

  logic [SIZE_W-1:0] nx, ny, nz;
  logic              x_wrap, y_wrap, z_wrap;
  logic              accept;

  logic [IDX_W-1:0]        sel_idx;
  logic [SIZE_W-1:0]       sel_n;
  logic [PHASE_W-1:0]      sel_step;
  logic signed [F_W-1:0]   freq;
  logic signed [F_W+PHASE_W:0] prod;
  logic [PHASE_W-1:0]      ang;
  logic                    fold;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] n);
    logic [SIZE_W-1:0] w;
    w = SIZE_W'(n);
    if (w == '0) begin
      return SIZE_W'(1);
    end
    if (w > SIZE_W'(MAX_DIM)) begin
      return SIZE_W'(MAX_DIM);
    end
    return w;
  endfunction

  assign cfg_ready = 1'b1;
  assign nx = eff_size(size_x_r);
  assign ny = eff_size(size_y_r);
  assign nz = eff_size(size_z_r);

  assign x_wrap = (SIZE_W'(x_index_r) + SIZE_W'(1)) >= nx;
  assign y_wrap = (SIZE_W'(y_index_r) + SIZE_W'(1)) >= ny;
  assign z_wrap = (SIZE_W'(z_index_r) + SIZE_W'(1)) >= nz;

  assign in_stall = (state_r != F_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    unique case (axis_r)
      AXIS_X: begin
        sel_idx = x_index_r; sel_n = nx; sel_step = step_x_r;
      end
      AXIS_Y: begin
        sel_idx = y_index_r; sel_n = ny; sel_step = step_y_r;
      end
      default: begin
        sel_idx = z_index_r; sel_n = nz; sel_step = step_z_r;
      end
    endcase
  end

  assign freq = (SIZE_W'(sel_idx) < (sel_n >> 1)) ? F_W'(sel_idx)
              : signed'(F_W'(sel_idx)) - signed'(F_W'(sel_n));
  assign prod = freq * signed'({1'b0, sel_step});

  assign ang  = PHASE_W'(0) - phi_r;
  assign fold = (ang[PHASE_W-1:PHASE_W-2] == 2'b01) || (ang[PHASE_W-1:PHASE_W-2] == 2'b10);

  assign push = (state_r == F_PUSH) && !q_stat.full;
  always_comb begin
    push_job.re   = smp_r.sample_re;
    push_job.im   = smp_r.sample_im;
    push_job.neg  = fold;
    push_job.ang  = signed'({ang[PHASE_W-1] ^ fold, ang[PHASE_W-2:0]});
    push_job.last = last_r;
  end

  always_comb begin
    state_nxt   = state_r;
    axis_nxt    = axis_r;
    phi_nxt     = phi_r;
    x_index_nxt = x_index_r;
    y_index_nxt = y_index_r;
    z_index_nxt = z_index_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          phi_nxt   = '0;
          axis_nxt  = AXIS_X;
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        phi_nxt = phi_r + prod[PHASE_W-1:0];
        if (axis_r == AXIS_Z) begin
          state_nxt = F_PUSH;
        end else begin
          axis_nxt = axis_t'(axis_r + 2'd1);
        end
      end
      F_PUSH: begin
        if (push) begin
          state_nxt = F_IDLE;
          if (x_wrap) begin
            x_index_nxt = '0;
            if (y_wrap) begin
              y_index_nxt = '0;
              z_index_nxt = z_wrap ? '0 : z_index_r + IDX_W'(1);
            end else begin
              y_index_nxt = y_index_r + IDX_W'(1);
            end
          end else begin
            x_index_nxt = x_index_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      axis_r    <= AXIS_X;
      x_index_r <= '0;
      y_index_r <= '0;
      z_index_r <= '0;
      size_x_r  <= CFG_SIZE_W'(1);
      size_y_r  <= CFG_SIZE_W'(1);
      size_z_r  <= CFG_SIZE_W'(1);
      step_x_r  <= '0;
      step_y_r  <= '0;
      step_z_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      axis_r    <= axis_nxt;
      x_index_r <= x_index_nxt;
      y_index_r <= y_index_nxt;
      z_index_r <= z_index_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SIZE_X: size_x_r <= cfg_data[CFG_SIZE_W-1:0];
          REG_SIZE_Y: size_y_r <= cfg_data[CFG_SIZE_W-1:0];
          REG_SIZE_Z: size_z_r <= cfg_data[CFG_SIZE_W-1:0];
          REG_STEP_X: step_x_r <= cfg_data[PHASE_W-1:0];
          REG_STEP_Y: step_y_r <= cfg_data[PHASE_W-1:0];
          REG_STEP_Z: step_z_r <= cfg_data[PHASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    phi_r <= phi_nxt;
    if (accept) begin
      smp_r  <= in_data;
      last_r <= x_wrap && y_wrap && z_wrap;
    end
  end

endmodule

>>> src/fsp_queue.sv
`timescale 1ns / 1ps
// Short register queue between the front end and the rotator.
module fsp_queue import fsp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head_job,
  output q_stat_t q_stat
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head_job     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign q_stat.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> src/fsp_back.sv
`timescale 1ns / 1ps
// Back end: gain prescale, iterative CORDIC rotation and saturating output.
module fsp_back import fsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_SCALE = 4'b0010,
    B_ROT   = 4'b0100,
    B_DONE  = 4'b1000
  } bstate_t;

  localparam int PROD_W = SAMPLE_W + 1 + GAIN_W + 1;
  localparam int RND_W  = VEC_W - SAMPLE_W + 1;

  bstate_t state_r, state_nxt;
  job_t    job_r;
  logic [ITER_W-1:0] iter_r;
  logic signed [VEC_W-1:0] vx_r, vy_r;
  logic signed [ANG_W-1:0] z_r;
  logic out_valid_r;
  out_item_t out_r;

  logic signed [SAMPLE_W:0]   re_s, im_s;
  logic signed [PROD_W-1:0]   px, py;
  logic signed [VEC_W-1:0]    dx, dy;
  logic signed [ANG_W-1:0]    tz;
  logic signed [RND_W-1:0]    rx, ry;
  logic                       slot_free;

  function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [RND_W-1:0] r);
    if (r > RND_W'(32767)) begin
      return SAMPLE_W'(32767);
    end
    if (r < -RND_W'(32768)) begin
      return SAMPLE_W'(-32768);
    end
    return r[SAMPLE_W-1:0];
  endfunction

  assign re_s = job_r.neg ? -signed'({job_r.re[SAMPLE_W-1], job_r.re})
                          : signed'({job_r.re[SAMPLE_W-1], job_r.re});
  assign im_s = job_r.neg ? -signed'({job_r.im[SAMPLE_W-1], job_r.im})
                          : signed'({job_r.im[SAMPLE_W-1], job_r.im});
  assign px = re_s * signed'({1'b0, CORDIC_GAIN_Q30});
  assign py = im_s * signed'({1'b0, CORDIC_GAIN_Q30});

  assign dx = vy_r >>> iter_r;
  assign dy = vx_r >>> iter_r;
  assign tz = signed'(ANG_W'(atan_turn(TAB_W'(iter_r))));

  assign rx = RND_W'((vx_r + VEC_W'(16384)) >>> SAMPLE_W - 1);
  assign ry = RND_W'((vy_r + VEC_W'(16384)) >>> SAMPLE_W - 1);

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = (state_r == B_IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (pop) state_nxt = B_SCALE;
      B_SCALE: state_nxt = B_ROT;
      B_ROT:   if (iter_r == ITER_W'(STAGES_EFF - 1)) state_nxt = B_DONE;
      B_DONE:  if (slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_DONE) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (pop) begin
          job_r <= head_job;
        end
      end
      B_SCALE: begin
        vx_r   <= VEC_W'(px >>> SAMPLE_W - 1);
        vy_r   <= VEC_W'(py >>> SAMPLE_W - 1);
        z_r    <= ANG_W'(job_r.ang);
        iter_r <= '0;
      end
      B_ROT: begin
        if (!z_r[ANG_W-1]) begin
          vx_r <= vx_r - dx;
          vy_r <= vy_r + dy;
          z_r  <= z_r - tz;
        end else begin
          vx_r <= vx_r + dx;
          vy_r <= vy_r - dy;
          z_r  <= z_r + tz;
        end
        iter_r <= iter_r + ITER_W'(1);
      end
      B_DONE: begin
        if (slot_free) begin
          out_r.out_re     <= sat_q15(rx);
          out_r.out_im     <= sat_q15(ry);
          out_r.frame_last <= job_r.last;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/fourier_shift_phase_ramp.sv
`timescale 1ns / 1ps
// Top level of the Fourier shift phase ramp rotator.
// Rotates each complex Q1.15 Fourier sample, taken in raster order (x fastest), by
// exp(-j*2*pi*(fx*step_x + fy*step_y + fz*step_z)) and returns it rounded and
// saturated, with frame_last set on the last sample of a frame. The front end
// takes a sample, forms three phase products on one multiplier and pushes to the
// queue (waiting while it is full) before it takes the next. The back end pops a
// sample, prescales it, runs the iterative CORDIC rotation and loads the output
// before it pops the next, so this CORDIC loop sets the sustained rate. A two-entry
// queue lets the front classify the next sample while the back is rotating. Sizes
// and steps must be written through the cfg port only while no sample is in flight;
// the block does not enforce this. Raster counters are not cleared by such writes.
module fourier_shift_phase_ramp import fsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  logic    q_push, q_pop;
  job_t    push_job, head_job;
  q_stat_t q_stat;

  fsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (q_push),
    .push_job  (push_job),
    .q_stat    (q_stat)
  );

  fsp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  fsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_job  (head_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_in_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front accepted an item while still classifying");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_stat.count != '0))
    else $error("back popped an empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("front pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> sim/tb_fourier_shift_phase_ramp.sv
`timescale 1ns / 1ps
// Self-checking testbench: streams samples through the phase ramp rotator and checks each item.
module tb_fourier_shift_phase_ramp;
  import fsp_pkg::*;

  localparam int     ITEM_TARGET = 1850;
  localparam int     ROT_STAGES  = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam longint ROT_GAIN    = 652032874;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    cfg_reg_t   target;
    logic [31:0] value;
    in_item_t   smp;
    logic       fixed;
    out_item_t  want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  longint rot_turns [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [10:0] sz_x = 11'd1, sz_y = 11'd1, sz_z = 11'd1;
  logic [31:0] st_x = '0, st_y = '0, st_z = '0;
  int unsigned ix = 0, iy = 0, iz = 0;

  out_item_t rotated_q [$];
  int        mismatches = 0;
  int        results_seen = 0;
  bit        src_idle = 1'b1;
  bit        sink_idle = 1'b1;
  dir_row_t  script [$];

  fourier_shift_phase_ramp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned fit_size(logic [10:0] n);
    if (n == 0) return 1;
    if (n > MAX_DIM) return MAX_DIM;
    return 32'(n);
  endfunction

  function automatic logic [31:0] axis_turns(int unsigned idx, int unsigned n, logic [31:0] step);
    logic [31:0] f;
    logic [63:0] p;
    f = (idx < n / 2) ? idx : idx - n;
    p = 64'(f) * 64'(step);
    return p[31:0];
  endfunction

  function automatic logic signed [15:0] to_sample(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Rotate one sample at the current raster position, then advance the position.
  function automatic out_item_t ramp_rotate(in_item_t s);
    int unsigned nx, ny, nz;
    logic [31:0] phi, ang;
    longint re, im, vx, vy, z, dx, dy;
    out_item_t o;
    nx = fit_size(sz_x);
    ny = fit_size(sz_y);
    nz = fit_size(sz_z);
    phi = axis_turns(ix, nx, st_x) + axis_turns(iy, ny, st_y) + axis_turns(iz, nz, st_z);
    ang = 32'd0 - phi;
    re = longint'($signed(s.sample_re));
    im = longint'($signed(s.sample_im));
    if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
      re = -re;
      im = -im;
      ang = ang + 32'h8000_0000;
    end
    z = longint'($signed(ang));
    vx = (re * ROT_GAIN) >>> 15;
    vy = (im * ROT_GAIN) >>> 15;
    for (int i = 0; i < ROT_STAGES; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (z >= 0) begin
        vx = vx - dx;
        vy = vy + dy;
        z = z - rot_turns[i];
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        z = z + rot_turns[i];
      end
    end
    o.out_re = to_sample(vx);
    o.out_im = to_sample(vy);
    o.frame_last = (ix + 1 >= nx) && (iy + 1 >= ny) && (iz + 1 >= nz);
    if (ix + 1 >= nx) begin
      ix = 0;
      if (iy + 1 >= ny) begin
        iy = 0;
        if (iz + 1 >= nz) iz = 0;
        else iz = iz + 1;
      end else begin
        iy = iy + 1;
      end
    end else begin
      ix = ix + 1;
    end
    return o;
  endfunction

  function automatic dir_row_t smp(int re, int im);
    dir_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.smp.sample_re = re[15:0];
    r.smp.sample_im = im[15:0];
    return r;
  endfunction

  function automatic dir_row_t smp_fixed(int re, int im, int want_re, int want_im, bit last);
    dir_row_t r;
    r = smp(re, im);
    r.fixed = 1'b1;
    r.want.out_re = want_re[15:0];
    r.want.out_im = want_im[15:0];
    r.want.frame_last = last;
    return r;
  endfunction

  function automatic dir_row_t wr(cfg_reg_t target, logic [31:0] value);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.target = target;
    r.value = value;
    return r;
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 15))
      0: return 32'd0;
      1: return $urandom_range(0, 2047);
      2: return MAX_DIM;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return {4'($urandom_range(0, 15)), 28'h0};
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on item %0d, %s: got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic send_sample(in_item_t s, logic fixed, out_item_t want);
    int gap;
    out_item_t exp_item;
    gap = src_idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_item = ramp_rotate(s);
    if (fixed) exp_item = want;
    rotated_q.push_back(exp_item);
  endtask

  // Hold input low until every pending item has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (rotated_q.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t target, logic [31:0] value, bit more);
    cfg_index <= target;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!more) cfg_valid <= 1'b0;
    case (target)
      REG_SIZE_X: sz_x = value[10:0];
      REG_SIZE_Y: sz_y = value[10:0];
      REG_SIZE_Z: sz_z = value[10:0];
      REG_STEP_X: st_x = value;
      REG_STEP_Y: st_y = value;
      REG_STEP_Z: st_z = value;
      default: ;
    endcase
  endtask

  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = sink_idle ? $urandom_range(0, 14) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = rotated_q.pop_front();
        if (out_data.out_re !== want.out_re)
          report_mismatch("out_re", $signed(out_data.out_re), $signed(want.out_re));
        if (out_data.out_im !== want.out_im)
          report_mismatch("out_im", $signed(out_data.out_im), $signed(want.out_im));
        if (out_data.frame_last !== want.frame_last)
          report_mismatch("frame_last", out_data.frame_last, want.frame_last);
      end
      results_seen++;
    end
  end

  initial begin
    int sent;
    int phase;
    int count;
    bit deep;
    in_item_t s;
    sent = 0;
    phase = 0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SIZE_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    script.push_back(smp_fixed(0, 0, 0, 0, 1'b1));
    script.push_back(smp(32767, 32767));
    script.push_back(smp(-32768, -32768));
    script.push_back(smp(-32768, 32767));
    script.push_back(smp(32767, -32768));
    script.push_back(wr(REG_SIZE_X, 32'd4));
    script.push_back(wr(REG_SIZE_Y, 32'd3));
    script.push_back(wr(REG_SIZE_Z, 32'd0));
    script.push_back(wr(REG_STEP_X, 32'h4000_0000));
    script.push_back(wr(REG_STEP_Y, 32'hFFFF_FFFF));
    script.push_back(wr(REG_STEP_Z, 32'h8000_0000));
    script.push_back(smp(32767, 0));
    script.push_back(smp(0, 32767));
    script.push_back(smp(-32768, 0));
    script.push_back(smp_fixed(0, 0, 0, 0, 1'b0));
    script.push_back(smp(0, -32768));
    script.push_back(smp(32767, 32767));
    script.push_back(smp(-32768, -32768));
    script.push_back(smp(12345, -23456));
    script.push_back(smp(-1, 1));
    script.push_back(smp(100, -100));
    script.push_back(smp(1, 0));
    script.push_back(smp_fixed(0, 0, 0, 0, 1'b1));

    for (int r = 0; r < script.size(); r++) begin
      if (script[r].kind == ROW_WRITE) begin
        if (r == 0 || script[r-1].kind != ROW_WRITE) drain_results();
        write_reg(script[r].target, script[r].value,
                  r + 1 < script.size() && script[r+1].kind == ROW_WRITE);
      end else begin
        send_sample(script[r].smp, script[r].fixed, script[r].want);
        sent++;
      end
    end

    while (sent < ITEM_TARGET) begin
      drain_results();
      deep = (phase == 3);
      write_reg(REG_SIZE_X, deep ? 32'd2047 : pick_size(), 1'b1);
      write_reg(REG_SIZE_Y, deep ? 32'($urandom_range(0, 1)) : pick_size(), 1'b1);
      write_reg(REG_SIZE_Z, deep ? 32'd1 : pick_size(), 1'b1);
      write_reg(REG_STEP_X, pick_step(), 1'b1);
      write_reg(REG_STEP_Y, pick_step(), 1'b1);
      write_reg(REG_STEP_Z, pick_step(), 1'b0);
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      count = deep ? 640 : $urandom_range(16, 72);
      repeat (count) begin
        s.sample_re = SAMPLE_W'($urandom);
        s.sample_im = SAMPLE_W'($urandom);
        send_sample(s, 1'b0, '0);
        sent++;
        if ($urandom_range(0, 63) == 0) drain_results();
      end
      phase++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
